// ===== hw/rtl/ibdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ibdp_pkg
// Shared types, slot constants and slot lookup functions for the indoor bike
// data parser.
// ----------------------------------------------------------------------------
package ibdp_pkg;

    localparam int unsigned SLOT_COUNT = 13;
    localparam logic [3:0]  SLOT_DONE  = 4'd13;

    // Capture indexes, same order as the present mask
    localparam logic [2:0] CAP_SPEED    = 3'd0;
    localparam logic [2:0] CAP_CADENCE  = 3'd1;
    localparam logic [2:0] CAP_DISTANCE = 3'd2;
    localparam logic [2:0] CAP_RESIST   = 3'd3;
    localparam logic [2:0] CAP_INST_PWR = 3'd4;
    localparam logic [2:0] CAP_AVG_PWR  = 3'd5;
    localparam logic [2:0] CAP_ENERGY   = 3'd6;
    localparam logic [2:0] CAP_ELAPSED  = 3'd7;

    // Flag bit for "more data": speed is present when it is clear
    localparam int unsigned FLAG_MORE_DATA = 0;

    localparam int unsigned RESULT_BITS = 161;
    localparam int unsigned TDATA_BITS  = 168;

    typedef struct packed {
        logic [1:0]  hdr_cnt;
        logic [15:0] flags;
        logic [3:0]  slot;
        logic [2:0]  bif;
        logic [7:0]  present;
    } walk_state_t;

    typedef struct packed {
        logic       wr_en;
        logic [2:0] wr_idx;
        logic [1:0] wr_lane;
        logic       ok;
    } walk_upd_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] idx;
    } cap_sel_t;

    function automatic logic [2:0] slot_width(input logic [3:0] s);
        logic [2:0] w;
        unique case (s)
            4'd4:          w = 3'd3;
            4'd8:          w = 3'd5;
            4'd9, 4'd10:   w = 3'd1;
            default:       w = 3'd2;
        endcase
        return w;
    endfunction

    function automatic cap_sel_t slot_capture(input logic [3:0] s);
        cap_sel_t c;
        c = '{valid: 1'b1, idx: CAP_SPEED};
        unique case (s)
            4'd0:    c.idx = CAP_SPEED;
            4'd2:    c.idx = CAP_CADENCE;
            4'd4:    c.idx = CAP_DISTANCE;
            4'd5:    c.idx = CAP_RESIST;
            4'd6:    c.idx = CAP_INST_PWR;
            4'd7:    c.idx = CAP_AVG_PWR;
            4'd8:    c.idx = CAP_ENERGY;
            4'd11:   c.idx = CAP_ELAPSED;
            default: c.valid = 1'b0;
        endcase
        return c;
    endfunction

    // First present slot at or after 'from'; SLOT_DONE when none is left
    function automatic logic [3:0] next_slot(input logic [15:0] flags,
                                             input logic [3:0]  from);
        logic [SLOT_COUNT-1:0] pres;
        logic [3:0]            res;
        pres    = flags[SLOT_COUNT-1:0];
        pres[0] = ~flags[FLAG_MORE_DATA];
        res     = SLOT_DONE;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (pres[i] && (4'(i) >= from)) begin
                res = 4'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/ibdp_field_walk.sv =====
// ----------------------------------------------------------------------------
// ibdp_field_walk
// Next-state logic for one packet byte: header assembly, slot walk and
// capture write selection.
// ----------------------------------------------------------------------------
module ibdp_field_walk
    import ibdp_pkg::*;
(
    input  walk_state_t cur,
    input  logic [7:0]  data_byte,
    output walk_state_t nxt,
    output walk_upd_t   upd
);

    logic       hdr_done;
    logic [3:0] s;
    cap_sel_t   cap;
    logic [2:0] cap_len;
    logic [3:0] k_plus;

    assign hdr_done = (cur.hdr_cnt == 2'd2);
    assign s        = next_slot(cur.flags, cur.slot);
    assign cap      = slot_capture(s);
    assign cap_len  = (cap.idx == CAP_DISTANCE) ? 3'd3 : 3'd2;
    assign k_plus   = {1'b0, cur.bif} + 4'd1;

    always_comb
    begin
        nxt         = cur;
        upd.wr_en   = 1'b0;
        upd.wr_idx  = cap.idx;
        upd.wr_lane = cur.bif[1:0];
        if (!hdr_done)
        begin
            // collect the flag word, low byte first
            if (cur.hdr_cnt[0])
            begin
                nxt.flags[15:8] = data_byte;
            end
            else
            begin
                nxt.flags[7:0] = data_byte;
            end
            nxt.hdr_cnt = cur.hdr_cnt + 2'd1;
        end
        else if (s != SLOT_DONE)
        begin
            upd.wr_en = cap.valid && (cur.bif < cap_len);
            if (k_plus >= {1'b0, slot_width(s)})
            begin
                if (cap.valid)
                begin
                    nxt.present[cap.idx] = 1'b1;
                end
                nxt.slot = s + 4'd1;
                nxt.bif  = 3'd0;
            end
            else
            begin
                nxt.slot = s;
                nxt.bif  = cur.bif + 3'd1;
            end
        end
        upd.ok = (nxt.hdr_cnt == 2'd2) && (next_slot(nxt.flags, nxt.slot) == SLOT_DONE);
    end

endmodule

// ===== hw/rtl/indoor_bike_data_parser_top.sv =====
// ----------------------------------------------------------------------------
// indoor_bike_data_parser_top
// Byte-stream parser for indoor bike data packets: flag word, optional
// fields in flag order, one result per packet on its last byte.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                          Item
//  s_axis    in   tvalid tready tdata[7:0] tlast   one packet byte
//  m_axis    out  tvalid tready tdata[167:0]       one decoded packet
//
//  Timing: one byte per clock; the result of a packet is offered in the
//  cycle after its last byte is taken. The throughput is set by the single
//  result register: a new byte is taken whenever that register is empty or
//  being drained. Reset clears the parse state and the result valid at once.
//  While a result waits, no byte is taken unless the result register frees
//  up in the same cycle (tready follows it).
//
module indoor_bike_data_parser_top
    import ibdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte[7:0]
    input  logic                  s_axis_tlast,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // ok[0], flag_word[16:1], present_mask[24:17], speed[40:25],
    // cadence[56:41], distance[80:57], resistance[96:81],
    // inst_power[112:97], avg_power[128:113], energy[144:129],
    // elapsed[160:145], zero pad above
    output logic [TDATA_BITS-1:0] m_axis_tdata
);

    walk_state_t state_reg;
    walk_state_t state_next;
    walk_upd_t   upd;

    // captured values: low two bytes for every field, third byte for distance
    logic [15:0] val_reg  [8];
    logic [15:0] val_next [8];
    logic [7:0]  dist_hi_reg;
    logic [7:0]  dist_hi_next;

    logic                   out_valid_reg;
    logic [RESULT_BITS-1:0] out_data_reg;
    logic [RESULT_BITS-1:0] out_data_next;
    logic [15:0]            shown [8];

    logic in_acc;
    logic pkt_end;

    // The output register frees up when taken, so the input side never waits
    // on an empty or draining result.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pkt_end       = in_acc && s_axis_tlast;

    ibdp_field_walk u_walk (
        .cur       (state_reg),
        .data_byte (s_axis_tdata),
        .nxt       (state_next),
        .upd       (upd)
    );

    // Apply this byte to the capture registers
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            val_next[i] = val_reg[i];
        end
        dist_hi_next = dist_hi_reg;
        if (upd.wr_en)
        begin
            unique case (upd.wr_lane)
                2'd0:    val_next[upd.wr_idx][7:0]  = s_axis_tdata;
                2'd1:    val_next[upd.wr_idx][15:8] = s_axis_tdata;
                default: dist_hi_next                = s_axis_tdata;
            endcase
        end
    end

    // Build the result from the state as it stands after this byte;
    // fields that never completed read as zero.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            shown[i] = state_next.present[i] ? val_next[i] : 16'd0;
        end
        out_data_next = {
            shown[CAP_ELAPSED],
            shown[CAP_ENERGY],
            shown[CAP_AVG_PWR],
            shown[CAP_INST_PWR],
            shown[CAP_RESIST],
            (state_next.present[CAP_DISTANCE] ? dist_hi_next : 8'd0),
            shown[CAP_DISTANCE],
            shown[CAP_CADENCE],
            shown[CAP_SPEED],
            state_next.present,
            ((state_next.hdr_cnt == 2'd2) ? state_next.flags : 16'd0),
            upd.ok
        };
    end

    // Parse state: advance on every byte, drop back to reset after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (pkt_end)
        begin
            state_reg <= '0;
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    // Capture payload; stale bytes are masked by the present bits
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < 8; i++)
            begin
                val_reg[i] <= val_next[i];
            end
            dist_hi_reg <= dist_hi_next;
        end
    end

    // Result register: hold until taken, load on a packet end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pkt_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_end)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_BITS - RESULT_BITS){1'b0}}, out_data_reg};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------

    // input side only stalls behind a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // a packet end returns the walk to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_end |=> (state_reg.hdr_cnt == 2'd0) && (state_reg.present == 8'd0)
                    && (state_reg.slot == 4'd0))
        else $error("parse state not cleared after packet end");

    // header counter never passes two
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hdr_cnt != 2'd3)
        else $error("header count out of range");

    // a complete packet reports speed exactly when the flag calls for it
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_data_reg[0]) |->
            (out_data_reg[17] == !out_data_reg[1]))
        else $error("speed presence disagrees with flag word");

endmodule

// ===== dv/indoor_bike_data_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the indoor bike data parser: packets of bytes go in,
// one decoded result per packet comes out and is checked field by field
// against a packet walker kept inside this bench.
// ----------------------------------------------------------------------------
module testbench;
    import ibdp_pkg::*;

    localparam int NO_CAP     = -1;
    localparam int SLOT_TOTAL = 13;
    localparam int PRINT_CAP  = 100;

    // Result item as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [15:0]        elapsed;
        logic [15:0]        energy;
        logic signed [15:0] avg_power;
        logic signed [15:0] inst_power;
        logic signed [15:0] resistance;
        logic [23:0]        distance;
        logic [15:0]        cadence;
        logic [15:0]        speed;
        logic [7:0]         present_mask;
        logic [15:0]        flag_word;
        logic               ok;
    } decoded_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_axis_tdata;

    // Idle percentages of the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int error_count = 0;

    // Walker state: mirrors the parse progress through the current packet
    int          hdr_seen;
    logic [15:0] flags_seen;
    int          cur_slot;
    int          cur_byte;
    logic [23:0] captured [8];
    logic [7:0]  captured_done;

    decoded_t decoded_queue [$];
    decoded_t got_result;

    indoor_bike_data_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Field layout after the flag word
    // ------------------------------------------------------------------------

    // Bytes that each optional field occupies on the wire
    function automatic int slot_len(input int s);
        case (s)
            4:       return 3;
            8:       return 5;
            9, 10:   return 1;
            default: return 2;
        endcase
    endfunction

    // Which captured value a field lands in, or NO_CAP for skipped fields
    function automatic int slot_cap(input int s);
        case (s)
            0:       return int'(CAP_SPEED);
            2:       return int'(CAP_CADENCE);
            4:       return int'(CAP_DISTANCE);
            5:       return int'(CAP_RESIST);
            6:       return int'(CAP_INST_PWR);
            7:       return int'(CAP_AVG_PWR);
            8:       return int'(CAP_ENERGY);
            11:      return int'(CAP_ELAPSED);
            default: return NO_CAP;
        endcase
    endfunction

    // Distance keeps three bytes; energy keeps only the first two of five
    function automatic int cap_len(input int c);
        return (c == int'(CAP_DISTANCE)) ? 3 : 2;
    endfunction

    // Speed is carried when the "more data" flag is clear, the rest when their own flag bit is set
    function automatic bit slot_on(input logic [15:0] flags, input int s);
        if (s == 0)
            return !flags[FLAG_MORE_DATA];
        return flags[s];
    endfunction

    function automatic int first_live_slot(input logic [15:0] flags, input int from);
        for (int s = from; s < SLOT_TOTAL; s++)
        begin
            if (slot_on(flags, s))
                return s;
        end
        return SLOT_TOTAL;
    endfunction

    function automatic int full_packet_len(input logic [15:0] flags);
        int n;
        n = 2;
        for (int s = 0; s < SLOT_TOTAL; s++)
        begin
            if (slot_on(flags, s))
                n += slot_len(s);
        end
        return n;
    endfunction

    function automatic void clear_walk();
        hdr_seen      = 0;
        flags_seen    = '0;
        cur_slot      = 0;
        cur_byte      = 0;
        captured_done = '0;
        for (int i = 0; i < 8; i++)
            captured[i] = '0;
    endfunction

    // Advance the walker by one accepted byte; on the last byte queue the
    // decoded packet and start over
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        int       s;
        int       cap;
        decoded_t d;
        logic [23:0] v [8];
        if (hdr_seen < 2)
        begin
            flags_seen = flags_seen | (16'(b) << (8 * hdr_seen));
            hdr_seen++;
        end
        else
        begin
            s = first_live_slot(flags_seen, cur_slot);
            if (s < SLOT_TOTAL)
            begin
                cap = slot_cap(s);
                if (cap != NO_CAP && cur_byte < cap_len(cap))
                    captured[cap] = captured[cap] | (24'(b) << (8 * cur_byte));
                if (cur_byte + 1 >= slot_len(s))
                begin
                    if (cap != NO_CAP)
                        captured_done[cap] = 1'b1;
                    cur_slot = s + 1;
                    cur_byte = 0;
                end
                else
                begin
                    cur_slot = s;
                    cur_byte = cur_byte + 1;
                end
            end
        end
        if (!last)
            return;
        // Unfinished fields report as zero with their mask bit clear
        for (int i = 0; i < 8; i++)
            v[i] = captured_done[i] ? captured[i] : 24'd0;
        d              = '0;
        d.ok           = (hdr_seen >= 2) &&
                         (first_live_slot(flags_seen, cur_slot) == SLOT_TOTAL);
        d.flag_word    = (hdr_seen >= 2) ? flags_seen : 16'd0;
        d.present_mask = captured_done;
        d.speed        = v[CAP_SPEED][15:0];
        d.cadence      = v[CAP_CADENCE][15:0];
        d.distance     = v[CAP_DISTANCE];
        d.resistance   = v[CAP_RESIST][15:0];
        d.inst_power   = v[CAP_INST_PWR][15:0];
        d.avg_power    = v[CAP_AVG_PWR][15:0];
        d.energy       = v[CAP_ENERGY][15:0];
        d.elapsed      = v[CAP_ELAPSED][15:0];
        decoded_queue.push_back(d);
        clear_walk();
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_result(input decoded_t got, input decoded_t want);
        if (got.ok !== want.ok)
            report_mismatch("ok", 32'(got.ok), 32'(want.ok));
        if (got.flag_word !== want.flag_word)
            report_mismatch("flag_word", 32'(got.flag_word), 32'(want.flag_word));
        if (got.present_mask !== want.present_mask)
            report_mismatch("present_mask", 32'(got.present_mask), 32'(want.present_mask));
        if (got.speed !== want.speed)
            report_mismatch("speed", 32'(got.speed), 32'(want.speed));
        if (got.cadence !== want.cadence)
            report_mismatch("cadence", 32'(got.cadence), 32'(want.cadence));
        if (got.distance !== want.distance)
            report_mismatch("distance", 32'(got.distance), 32'(want.distance));
        if (got.resistance !== want.resistance)
            report_mismatch("resistance", 32'(got.resistance), 32'(want.resistance));
        if (got.inst_power !== want.inst_power)
            report_mismatch("inst_power", 32'(got.inst_power), 32'(want.inst_power));
        if (got.avg_power !== want.avg_power)
            report_mismatch("avg_power", 32'(got.avg_power), 32'(want.avg_power));
        if (got.energy !== want.energy)
            report_mismatch("energy", 32'(got.energy), 32'(want.energy));
        if (got.elapsed !== want.elapsed)
            report_mismatch("elapsed", 32'(got.elapsed), 32'(want.elapsed));
        if (got.pad !== want.pad)
            report_mismatch("tdata pad", 32'(got.pad), 32'(want.pad));
    endtask

    // Everything is driven with nonblocking assignments, so values read here
    // are the ones that were stable before this edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result = decoded_t'(m_axis_tdata);
            if (decoded_queue.size() == 0)
                report_mismatch("result with none expected", 32'(got_result.flag_word), 0);
            else
                check_result(got_result, decoded_queue.pop_front());
        end
    end

    // Receiver: stall at random according to the phase
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one byte after a random idle gap, hold it until taken, then feed
    // the walker. Called on a rising edge, returns on the accepting edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        parse_byte(b, last);
    endtask

    task automatic send_packet(input logic [7:0] pkt [$]);
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Drop valid and hold until every queued packet result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_queue.size() != 0)
            @(posedge clk);
    endtask

    // A single byte never completes the flag word
    task automatic test_short_header();
        send_packet('{8'hA5});
    endtask

    // Header-only packets: every flag set leaves every flagged field missing; only the
    // "more data" flag set means no field is expected at all
    task automatic test_flag_word();
        send_packet('{8'hFF, 8'hFF});
        send_packet('{8'h01, 8'h00});
    endtask

    task automatic test_speed_extremes();
        send_packet('{8'h00, 8'h00, 8'hFF, 8'hFF});
    endtask

    // Bytes past the last flagged field are ignored and ok holds
    task automatic test_trailing_bytes();
        send_packet('{8'h01, 8'h00, 8'h5A, 8'hC3});
    endtask

    // Distance cut after two of its three bytes
    task automatic test_truncated_field();
        send_packet('{8'h11, 8'h00, 8'h34, 8'h12});
    endtask

    // Resistance at the signed minimum, instantaneous power at the signed maximum, average power just above the minimum
    task automatic test_signed_extremes();
        send_packet('{8'hE1, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h80});
    endtask

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly complete packets with random flags and content; the rest carry
    // trailing bytes, stop short of the full length, or stop inside the flag word
    task automatic test_random_packets(input int send_pct, input int recv_pct,
                                       input int byte_budget);
        logic [7:0]  pkt [$];
        logic [15:0] flags;
        int          full;
        int          len;
        int          kind;
        int          sent;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < byte_budget)
        begin
            flags = 16'($urandom);
            full  = full_packet_len(flags);
            kind  = $urandom_range(0, 99);
            if (kind < 70)
                len = full;
            else if (kind < 82)
                len = full + $urandom_range(1, 4);
            else if (kind < 95)
                len = $urandom_range(1, full - 1);
            else
                len = 1;
            pkt.delete();
            pkt.push_back(flags[7:0]);
            if (len > 1)
                pkt.push_back(flags[15:8]);
            while (pkt.size() < len)
                pkt.push_back(content_byte());
            send_packet(pkt);
            sent += len;
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_walk();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with no idling on either side
        test_short_header();
        test_flag_word();
        test_speed_extremes();
        test_trailing_bytes();
        test_truncated_field();
        test_signed_extremes();
        wait_drained();

        // Random packets through each idling mix
        test_random_packets(0, 0, 440);
        test_random_packets(46, 0, 440);
        test_random_packets(0, 46, 440);
        test_random_packets(26, 26, 440);

        // Give a stray extra result time to show up
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("indoor_bike_data_parser_top: match");
        else
            $display("indoor_bike_data_parser_top: mismatch");
        $finish;
    end

    // Run guard, far above the slowest expected run
    initial
    begin
        #5_000_000;
        $display("indoor_bike_data_parser_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ibdp_pkg.sv
hw/rtl/ibdp_field_walk.sv
hw/rtl/indoor_bike_data_parser_top.sv
dv/indoor_bike_data_parser_tb.sv
